[rtl/gbn_pkg.sv]
// Package for the Go-Back-N sender window unit.
// Holds the window constants, field widths, event and action codes and the
// command/status structs shared by the controller and datapath.
`default_nettype none

package gbn_pkg;

  // Window geometry and packet size
  localparam int unsigned WINDOW    = 6;
  localparam int unsigned SEQ_SPACE = 10;
  localparam int unsigned PAYLOAD   = 1000;

  // Field widths
  localparam int unsigned SEQ_W  = 4;
  localparam int unsigned LEN_W  = 10;
  localparam int unsigned BYTE_W = 24;
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SSUM_W = SLOT_W + 1;
  localparam int unsigned QSUM_W = SEQ_W + 1;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_ACK     = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_NOP     = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ACT_STATUS = 2'd0,
    ACT_SEND   = 2'd1,
    ACT_RETX   = 2'd2
  } action_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;      // latch a new event
    logic clear;       // start of transfer: clear window state
    logic release_one; // release the oldest outstanding packet
    logic emit_send;   // emit a new packet beat
    logic emit_retx;   // emit a retransmit beat
    logic emit_status; // emit the closing status beat
  } gbn_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;    // output register can take a beat this cycle
    logic can_fill;    // window has room and bytes remain
    logic ack_ok;      // incoming ACK lies in the outstanding window
    logic rel_last;    // current release is the final one
    logic retx_done;   // every outstanding packet has been resent
  } gbn_sts_t;

endpackage

`default_nettype wire

[rtl/go_back_n_sender_window_unit.sv]
// Go-Back-N sender window unit. An ACK event first releases each acknowledged packet in
// the S_REL state; the result beats of an event are then registered in the output register.
// Throughput: one result beat per cycle while the output is not stalled; every event ends
// with a status beat, and the next event is taken once the status beat is registered.
// Reset (rst_ni low, asynchronous) clears the window and transfer_bytes; the slot ring
// is left uninitialised.
`default_nettype none

module go_back_n_sender_window_unit
  import gbn_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // APB-style configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Event channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        opcode_i,
  input  logic [SEQ_W-1:0]  ack_seq_i,
  // Result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        action_o,
  output logic [SEQ_W-1:0]  seq_num_o,
  output logic [BYTE_W-1:0] data_offset_o,
  output logic [LEN_W-1:0]  data_length_o,
  output logic [BYTE_W-1:0] acked_total_o,
  output logic              done_res_o,
  output logic              last_o
);

  localparam logic [2:0] ADDR_TRANSFER = 3'd0;

  // Configuration register: transfer size. Written at the access phase.
  logic [BYTE_W-1:0] transfer_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_TRANSFER);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      transfer_q <= '0;
    end else if (cfg_wr) begin
      transfer_q <= pwdata[BYTE_W-1:0];
    end
  end

  // Read back the transfer size; any other address reads as zero
  assign prdata = (paddr == ADDR_TRANSFER) ? {{(32 - BYTE_W){1'b0}}, transfer_q} : '0;

  gbn_cmd_t cmd;
  gbn_sts_t sts;
  logic     busy;

  // Hold off new events until the current one has registered its status beat
  assign in_stall_o = busy;

  gbn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .busy_o     (busy),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gbn_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .transfer_bytes_i (transfer_q),
    .ack_seq_i        (ack_seq_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .action_o         (action_o),
    .seq_num_o        (seq_num_o),
    .data_offset_o    (data_offset_o),
    .data_length_o    (data_length_o),
    .acked_total_o    (acked_total_o),
    .done_res_o       (done_res_o),
    .last_o           (last_o)
  );

`ifndef SYNTHESIS
  // An accepted event keeps the block busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("event channel not stalled after an accepted beat");

  // The closing beat is a bare status item
  a_last_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |->
      (action_o == ACT_STATUS) && (seq_num_o == '0) && (data_length_o == '0))
    else $error("last beat is not a clean status item");

  // New packets carry a non-empty payload no larger than the packet size
  a_send_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (action_o == ACT_SEND)) |->
      (data_length_o != '0) && (data_length_o <= LEN_W'(PAYLOAD)) && !last_o)
    else $error("send beat with bad payload length");
`endif

endmodule

`default_nettype wire

[rtl/gbn_ctrl.sv]
// Controller state machine of the Go-Back-N sender window unit.
// Depends on gbn_pkg for event codes and the command/status structs.
`default_nettype none

module gbn_ctrl
  import gbn_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     opcode_i,
  output logic           busy_o,
  input  gbn_sts_t       sts_i,
  output gbn_cmd_t       cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_REL  = 3'd1;
  localparam logic [2:0] S_FILL = 3'd2;
  localparam logic [2:0] S_RETX = 3'd3;
  localparam logic [2:0] S_STAT = 3'd4;

  logic [2:0] state_q, state_d;

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (opcode_e'(opcode_i))
            OP_START: begin
              cmd_o.clear = 1'b1;
              state_d     = S_FILL;
            end
            OP_ACK:     state_d = sts_i.ack_ok ? S_REL : S_FILL;
            OP_TIMEOUT: state_d = S_RETX;
            default:    state_d = S_STAT;
          endcase
        end
      end
      S_REL: begin
        cmd_o.release_one = 1'b1;
        if (sts_i.rel_last) state_d = S_FILL;
      end
      S_FILL: begin
        if (!sts_i.can_fill) begin
          state_d = S_STAT;
        end else if (sts_i.out_free) begin
          cmd_o.emit_send = 1'b1;
        end
      end
      S_RETX: begin
        if (sts_i.retx_done) begin
          state_d = S_STAT;
        end else if (sts_i.out_free) begin
          cmd_o.emit_retx = 1'b1;
        end
      end
      S_STAT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_status = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[rtl/gbn_dp.sv]
// Datapath of the Go-Back-N sender window unit: window counters, byte
// counts, slot length ring and the output register. Depends on gbn_pkg.
`default_nettype none

module gbn_dp
  import gbn_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [BYTE_W-1:0] transfer_bytes_i,
  input  logic [SEQ_W-1:0]  ack_seq_i,
  input  gbn_cmd_t          cmd_i,
  output gbn_sts_t          sts_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        action_o,
  output logic [SEQ_W-1:0]  seq_num_o,
  output logic [BYTE_W-1:0] data_offset_o,
  output logic [LEN_W-1:0]  data_length_o,
  output logic [BYTE_W-1:0] acked_total_o,
  output logic              done_res_o,
  output logic              last_o
);

  logic [SEQ_W-1:0]  base_q, base_d, next_q, next_d;
  logic [CNT_W-1:0]  infl_q, infl_d;
  logic [SLOT_W-1:0] head_q, head_d;
  logic [BYTE_W-1:0] sent_q, sent_d, acked_q, acked_d;
  logic [SEQ_W-1:0]  rel_q, rel_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [BYTE_W-1:0] off_q, off_d;
  logic [LEN_W-1:0]  slot_q [WINDOW];

  logic              ovalid_q;
  logic [1:0]        act_q;
  logic [SEQ_W-1:0]  oseq_q;
  logic [BYTE_W-1:0] ooff_q, oacked_q;
  logic [LEN_W-1:0]  olen_q;
  logic              odone_q, olast_q;

  // ACK window check
  logic [QSUM_W-1:0] ack_ext, base_ext, ack_dist;
  logic              ack_in_space;
  always_comb begin
    ack_ext      = {1'b0, ack_seq_i};
    base_ext     = {1'b0, base_q};
    ack_in_space = (ack_ext < QSUM_W'(SEQ_SPACE));
    if (ack_ext >= base_ext) ack_dist = ack_ext - base_ext;
    else                     ack_dist = ack_ext + QSUM_W'(SEQ_SPACE) - base_ext;
  end

  // Sequence number of the retransmit beat, wrapped once
  logic [QSUM_W-1:0] rseq_sum, rseq_mod;
  always_comb begin
    rseq_sum = {1'b0, base_q} + QSUM_W'(idx_q);
    rseq_mod = (rseq_sum >= QSUM_W'(SEQ_SPACE)) ? rseq_sum - QSUM_W'(SEQ_SPACE) : rseq_sum;
  end

  // Ring positions for reading (head + idx) and writing (head + in_flight)
  logic [SSUM_W-1:0] rd_sum, wr_sum;
  logic [SLOT_W-1:0] rd_idx, wr_idx;
  always_comb begin
    rd_sum = {1'b0, head_q} + SSUM_W'(idx_q);
    wr_sum = {1'b0, head_q} + SSUM_W'(infl_q);
    rd_idx = (rd_sum >= SSUM_W'(WINDOW)) ? SLOT_W'(rd_sum - SSUM_W'(WINDOW))
                                         : SLOT_W'(rd_sum);
    wr_idx = (wr_sum >= SSUM_W'(WINDOW)) ? SLOT_W'(wr_sum - SSUM_W'(WINDOW))
                                         : SLOT_W'(wr_sum);
  end

  logic [LEN_W-1:0] rd_len;
  assign rd_len = slot_q[rd_idx];

  // Length of the next new packet, clipped to what remains
  logic [BYTE_W-1:0] remain;
  logic [LEN_W-1:0]  fill_len;
  always_comb begin
    remain   = transfer_bytes_i - sent_q;
    fill_len = (remain < BYTE_W'(PAYLOAD)) ? remain[LEN_W-1:0] : LEN_W'(PAYLOAD);
  end

  logic out_free;
  assign out_free = !ovalid_q || !out_stall_i;

  always_comb begin
    sts_o.out_free  = out_free;
    sts_o.can_fill  = (infl_q < CNT_W'(WINDOW)) && (sent_q < transfer_bytes_i);
    sts_o.ack_ok    = ack_in_space && (ack_dist < QSUM_W'(infl_q));
    sts_o.rel_last  = (rel_q == '0);
    sts_o.retx_done = (idx_q == infl_q);
  end

  // Next state of the window
  always_comb begin
    base_d  = base_q;
    next_d  = next_q;
    infl_d  = infl_q;
    head_d  = head_q;
    sent_d  = sent_q;
    acked_d = acked_q;
    rel_d   = rel_q;
    idx_d   = idx_q;
    off_d   = off_q;
    if (cmd_i.accept) begin
      rel_d = ack_dist[SEQ_W-1:0];
      idx_d = '0;
      off_d = acked_q;
    end
    if (cmd_i.clear) begin
      base_d  = '0;
      next_d  = '0;
      infl_d  = '0;
      head_d  = '0;
      sent_d  = '0;
      acked_d = '0;
    end
    if (cmd_i.release_one) begin
      acked_d = acked_q + BYTE_W'(rd_len);
      head_d  = (head_q == SLOT_W'(WINDOW - 1)) ? '0 : head_q + 1'b1;
      base_d  = (base_q == SEQ_W'(SEQ_SPACE - 1)) ? '0 : base_q + 1'b1;
      infl_d  = infl_q - 1'b1;
      rel_d   = rel_q - 1'b1;
    end
    if (cmd_i.emit_send) begin
      sent_d = sent_q + BYTE_W'(fill_len);
      next_d = (next_q == SEQ_W'(SEQ_SPACE - 1)) ? '0 : next_q + 1'b1;
      infl_d = infl_q + 1'b1;
    end
    if (cmd_i.emit_retx) begin
      idx_d = idx_q + 1'b1;
      off_d = off_q + BYTE_W'(rd_len);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      next_q   <= '0;
      infl_q   <= '0;
      head_q   <= '0;
      sent_q   <= '0;
      acked_q  <= '0;
      rel_q    <= '0;
      idx_q    <= '0;
      off_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      base_q  <= base_d;
      next_q  <= next_d;
      infl_q  <= infl_d;
      head_q  <= head_d;
      sent_q  <= sent_d;
      acked_q <= acked_d;
      rel_q   <= rel_d;
      idx_q   <= idx_d;
      off_q   <= off_d;
      if (cmd_i.emit_send || cmd_i.emit_retx || cmd_i.emit_status) begin
        ovalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Slot ring: written on each new packet, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_send) slot_q[wr_idx] <= fill_len;
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_send || cmd_i.emit_retx || cmd_i.emit_status) begin
      oacked_q <= acked_q;
      odone_q  <= (acked_q >= transfer_bytes_i);
      olast_q  <= cmd_i.emit_status;
      if (cmd_i.emit_send) begin
        act_q  <= ACT_SEND;
        oseq_q <= next_q;
        ooff_q <= sent_q;
        olen_q <= fill_len;
      end else if (cmd_i.emit_retx) begin
        act_q  <= ACT_RETX;
        oseq_q <= rseq_mod[SEQ_W-1:0];
        ooff_q <= off_q;
        olen_q <= rd_len;
      end else begin
        act_q  <= ACT_STATUS;
        oseq_q <= '0;
        ooff_q <= '0;
        olen_q <= '0;
      end
    end
  end

  assign out_valid_o   = ovalid_q;
  assign action_o      = act_q;
  assign seq_num_o     = oseq_q;
  assign data_offset_o = ooff_q;
  assign data_length_o = olen_q;
  assign acked_total_o = oacked_q;
  assign done_res_o    = odone_q;
  assign last_o        = olast_q;

endmodule

`default_nettype wire
